/* rtl/rgbc_pkg.sv */
package rgbc_pkg;

    // field widths
    localparam int CH_W       = 16;
    localparam int QUO_W      = 16;
    localparam int ATIME_W    = 8;
    localparam int GAIN_W     = 2;
    localparam int DEN_SCL_W  = 14;
    localparam int DEN_W      = 22;
    localparam int SUM_W      = 28;
    localparam int NUM_W      = SUM_W + 5;
    localparam int LNUM_W     = 32;
    localparam int CNUM_W     = 28;
    localparam int MR_W       = 24;
    localparam int MG_W       = 26;
    localparam int MB_W       = 25;

    // configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_ATIME = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN  = CFG_IDX_W'(1);

    localparam logic [ATIME_W-1:0] ATIME_RESET = ATIME_W'(255);
    localparam logic [GAIN_W-1:0]  GAIN_RESET  = GAIN_W'(0);

    // 240 times the analog gain for gain codes 1x, 4x, 16x, 60x
    localparam logic [DEN_SCL_W-1:0] DEN_SCALE [0:3] = '{
        DEN_SCL_W'(240), DEN_SCL_W'(960), DEN_SCL_W'(3840), DEN_SCL_W'(14400)
    };

    // channel weights in thousandths, and the color temperature scale and offset
    localparam int K_RED      = 136;
    localparam int K_GREEN    = 1000;
    localparam int K_BLUE     = 444;
    localparam int CCT_SCALE  = 3810;
    localparam int CCT_OFFSET = 1391;

    typedef struct packed {
        logic [CH_W-1:0] rc;
        logic [CH_W-1:0] gc;
        logic [CH_W-1:0] bc;
        logic            cct_invalid;
    } entry_t;

    typedef struct packed {
        logic lux_neg;
        logic lux_ovf;
        logic cct_ovf;
        logic cct_invalid;
    } flags_t;

endpackage

/* rtl/rgbc_if.sv */
interface rgbc_in_if;
    import rgbc_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red_raw;
    logic [CH_W-1:0] green_raw;
    logic [CH_W-1:0] blue_raw;
    logic [CH_W-1:0] clear_raw;

    modport source (output valid, red_raw, green_raw, blue_raw, clear_raw, input ready);
    modport sink (input valid, red_raw, green_raw, blue_raw, clear_raw, output ready);
endinterface

interface rgbc_out_if;
    import rgbc_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] lux;
    logic            lux_clipped;
    logic [CH_W-1:0] color_temp;
    logic            cct_invalid;

    modport source (output valid, lux, lux_clipped, color_temp, cct_invalid, input ready);
    modport sink (input valid, lux, lux_clipped, color_temp, cct_invalid, output ready);
endinterface

interface rgbc_cfg_if;
    import rgbc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* rtl/rgbc_lux_color_temperature_unit.sv */
// rgbc light sensor post-processing: lux and correlated color temperature
//
// sample: valid/ready channel with one raw red, green, blue and clear count per
//   transfer. result: valid/ready channel with lux, lux_clipped, color_temp and
//   cct_invalid, one transfer for every sample transfer, in order.
// cfg: write channel (index, data); index 0 is atime, index 1 is gain_code,
//   other indexes are dropped. ready is always high. write only while idle.
// throughput: one sample per clock, sustained, while result.ready stays high.
// path: a sample passes through the two 16-stage restoring dividers (one
//   quotient bit per stage) plus the front register, the queue and four
//   arithmetic/output stages.
// stall: a low result.ready with result.valid high freezes the whole back end;
//   the queue keeps taking from the front until full, then sample.ready drops.
// reset: clears all valid bits, the queue and the config registers
//   (atime = 255, gain 1x); nothing is in flight afterwards.
module rgbc_lux_color_temperature_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    rgbc_cfg_if.sink   cfg,
    rgbc_in_if.sink    sample,
    rgbc_out_if.source result
);
    import rgbc_pkg::*;

    logic [ATIME_W-1:0] atime_reg;
    logic [GAIN_W-1:0]  gain_reg;
    logic [8:0]         int_cycles;
    logic [DEN_W-1:0]   den_reg;
    logic [DEN_W-1:0]   den_next;

    // front to queue to back
    logic   q_push;
    entry_t q_push_data;
    logic   q_full;
    logic   q_pop;
    logic   q_nonempty;
    entry_t q_head;

    // config writes are always taken and land in the registers at the next edge
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            atime_reg <= ATIME_RESET;
            gain_reg  <= GAIN_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_ATIME: atime_reg <= cfg.data[ATIME_W-1:0];
                REG_GAIN:  gain_reg  <= cfg.data[GAIN_W-1:0];
                default:   ;
            endcase
        end
    end

    // lux divisor 240 * (256 - atime) * gain, refreshed every cycle; the user must
    // only change config while idle (not enforced) so it settles long before use
    assign int_cycles = 9'd256 - {1'b0, atime_reg};
    assign den_next   = {13'd0, int_cycles} * {8'd0, DEN_SCALE[gain_reg]};

    always_ff @(posedge clk)
    begin
        den_reg <= den_next;
    end

    // front: takes the sample, removes the infrared estimate
    rgbc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample),
        .q_full    (q_full),
        .push      (q_push),
        .push_data (q_push_data)
    );

    // short queue so front and back stall on their own
    rgbc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .full      (q_full),
        .nonempty  (q_nonempty),
        .head      (q_head)
    );

    // back: weighted sum, both divisions, clipping and the output register
    rgbc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .lux_den    (den_reg),
        .head_valid (q_nonempty),
        .head       (q_head),
        .pop        (q_pop),
        .result     (result)
    );

endmodule

/* rtl/rgbc_div_pipe.sv */
module rgbc_div_pipe (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [rgbc_pkg::LNUM_W-1:0] lux_num,
    input  logic [rgbc_pkg::DEN_W-1:0]  lux_den,
    input  logic [rgbc_pkg::CNUM_W-1:0] cct_num,
    input  logic [rgbc_pkg::CH_W-1:0]   cct_den,
    input  rgbc_pkg::flags_t       in_flags,
    output logic                   out_valid,
    output logic [rgbc_pkg::QUO_W-1:0]  lux_q,
    output logic [rgbc_pkg::QUO_W-1:0]  cct_q,
    output rgbc_pkg::flags_t       out_flags
);
    import rgbc_pkg::*;

    localparam int LCMP_W = DEN_W + QUO_W;
    localparam int CCMP_W = CH_W + QUO_W;

    logic              valid_reg [QUO_W];
    logic [LNUM_W-1:0] lrem_reg  [QUO_W];
    logic [DEN_W-1:0]  lden_reg  [QUO_W];
    logic [QUO_W-1:0]  lq_reg    [QUO_W];
    logic [CNUM_W-1:0] crem_reg  [QUO_W];
    logic [CH_W-1:0]   cden_reg  [QUO_W];
    logic [QUO_W-1:0]  cq_reg    [QUO_W];
    flags_t            flags_reg [QUO_W];

    // one quotient bit per stage, msb first
    for (genvar k = 0; k < QUO_W; k++)
    begin : g_stage
        logic              v_src;
        logic [LNUM_W-1:0] lrem_src;
        logic [DEN_W-1:0]  lden_src;
        logic [QUO_W-1:0]  lq_src;
        logic [CNUM_W-1:0] crem_src;
        logic [CH_W-1:0]   cden_src;
        logic [QUO_W-1:0]  cq_src;
        flags_t            flags_src;
        logic [LCMP_W-1:0] ltrial;
        logic [CCMP_W-1:0] ctrial;
        logic              lge;
        logic              cge;

        if (k == 0)
        begin : g_first
            assign v_src     = in_valid;
            assign lrem_src  = lux_num;
            assign lden_src  = lux_den;
            assign lq_src    = '0;
            assign crem_src  = cct_num;
            assign cden_src  = cct_den;
            assign cq_src    = '0;
            assign flags_src = in_flags;
        end
        else
        begin : g_next
            assign v_src     = valid_reg[k-1];
            assign lrem_src  = lrem_reg[k-1];
            assign lden_src  = lden_reg[k-1];
            assign lq_src    = lq_reg[k-1];
            assign crem_src  = crem_reg[k-1];
            assign cden_src  = cden_reg[k-1];
            assign cq_src    = cq_reg[k-1];
            assign flags_src = flags_reg[k-1];
        end

        assign ltrial = LCMP_W'(lden_src) << (QUO_W - 1 - k);
        assign ctrial = CCMP_W'(cden_src) << (QUO_W - 1 - k);
        assign lge    = LCMP_W'(lrem_src) >= ltrial;
        assign cge    = CCMP_W'(crem_src) >= ctrial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= v_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                lrem_reg[k]  <= lge ? LNUM_W'(LCMP_W'(lrem_src) - ltrial) : lrem_src;
                lden_reg[k]  <= lden_src;
                lq_reg[k]    <= lq_src | (QUO_W'(lge) << (QUO_W - 1 - k));
                crem_reg[k]  <= cge ? CNUM_W'(CCMP_W'(crem_src) - ctrial) : crem_src;
                cden_reg[k]  <= cden_src;
                cq_reg[k]    <= cq_src | (QUO_W'(cge) << (QUO_W - 1 - k));
                flags_reg[k] <= flags_src;
            end
        end
    end

    assign out_valid = valid_reg[QUO_W-1];
    assign lux_q     = lq_reg[QUO_W-1];
    assign cct_q     = cq_reg[QUO_W-1];
    assign out_flags = flags_reg[QUO_W-1];

endmodule

/* rtl/rgbc_front.sv */
module rgbc_front (
    input  logic             clk,
    input  logic             rst_n,
    rgbc_in_if.sink          sample,
    input  logic             q_full,
    output logic             push,
    output rgbc_pkg::entry_t push_data
);
    import rgbc_pkg::*;

    logic            valid_reg;
    logic            valid_next;
    logic [CH_W-1:0] red_reg;
    logic [CH_W-1:0] grn_reg;
    logic [CH_W-1:0] blu_reg;
    logic [CH_W-1:0] ir_reg;
    logic [CH_W+1:0] sum;
    logic [CH_W+1:0] excess;
    logic [CH_W-1:0] ir_next;
    logic [CH_W-1:0] rc;
    logic            take;

    assign sample.ready = !valid_reg || !q_full;
    assign take         = sample.valid && sample.ready;
    assign push         = valid_reg && !q_full;

    // infrared estimate, kept to 16 bits
    always_comb
    begin
        sum     = {2'b00, sample.red_raw} + {2'b00, sample.green_raw}
                + {2'b00, sample.blue_raw};
        excess  = sum - {2'b00, sample.clear_raw};
        ir_next = (sum > {2'b00, sample.clear_raw}) ? excess[CH_W:1] : '0;
    end

    always_comb
    begin
        if (take)
            valid_next = 1'b1;
        else if (push)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            red_reg <= sample.red_raw;
            grn_reg <= sample.green_raw;
            blu_reg <= sample.blue_raw;
            ir_reg  <= ir_next;
        end
    end

    // corrected channels wrap mod 2^16
    assign rc = red_reg - ir_reg;

    always_comb
    begin
        push_data.rc          = rc;
        push_data.gc          = grn_reg - ir_reg;
        push_data.bc          = blu_reg - ir_reg;
        push_data.cct_invalid = (rc == '0);
    end

endmodule

/* rtl/rgbc_queue.sv */
module rgbc_queue #(
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  rgbc_pkg::entry_t push_data,
    input  logic             pop,
    output logic             full,
    output logic             nonempty,
    output rgbc_pkg::entry_t head
);
    import rgbc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    entry_t        mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign full     = (count_reg == CW'(DEPTH));
    assign nonempty = (count_reg != '0);
    assign head     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/rgbc_back.sv */
module rgbc_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [rgbc_pkg::DEN_W-1:0] lux_den,
    input  logic                       head_valid,
    input  rgbc_pkg::entry_t           head,
    output logic                       pop,
    rgbc_out_if.source                 result
);
    import rgbc_pkg::*;

    logic              en;

    // product stage
    logic              s1_valid_reg;
    logic [MR_W-1:0]   mr_reg;
    logic [MG_W-1:0]   mg_reg;
    logic [MB_W-1:0]   mb_reg;
    logic [CNUM_W-1:0] cn1_reg;
    logic [CH_W-1:0]   rc1_reg;
    logic              inv1_reg;

    // weighted sum stage
    logic              s2_valid_reg;
    logic [SUM_W-1:0]  p_reg;
    logic [CNUM_W-1:0] cn2_reg;
    logic [CH_W-1:0]   rc2_reg;
    logic              inv2_reg;

    // times 31 stage
    logic              s3_valid_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [NUM_W-1:0]  p_ext;
    logic [CNUM_W-1:0] cn3_reg;
    logic [CH_W-1:0]   rc3_reg;
    logic              inv3_reg;

    flags_t            div_flags;
    logic              d_valid;
    logic [QUO_W-1:0]  lux_q;
    logic [QUO_W-1:0]  cct_q;
    flags_t            d_flags;

    logic [CH_W:0]     ct_sum;
    logic              out_valid_reg;
    logic [CH_W-1:0]   lux_reg;
    logic [CH_W-1:0]   lux_next;
    logic              clip_reg;
    logic [CH_W-1:0]   ct_reg;
    logic [CH_W-1:0]   ct_next;
    logic              inv_reg;

    // whole back end moves together unless the output is held
    assign en  = !out_valid_reg || result.ready;
    assign pop = en && head_valid;

    assign p_ext = {{(NUM_W - SUM_W){p_reg[SUM_W-1]}}, p_reg};

    always_comb
    begin
        div_flags.lux_neg     = num_reg[NUM_W-1];
        div_flags.lux_ovf     = (LNUM_W + 6)'(num_reg[LNUM_W-1:0])
                              >= {lux_den, {QUO_W{1'b0}}};
        div_flags.cct_ovf     = (CNUM_W + 4)'(cn3_reg) >= {rc3_reg, {QUO_W{1'b0}}};
        div_flags.cct_invalid = inv3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= head_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mr_reg   <= MR_W'(head.rc) * MR_W'(K_RED);
            mg_reg   <= MG_W'(head.gc) * MG_W'(K_GREEN);
            mb_reg   <= MB_W'(head.bc) * MB_W'(K_BLUE);
            cn1_reg  <= CNUM_W'(head.bc) * CNUM_W'(CCT_SCALE);
            rc1_reg  <= head.rc;
            inv1_reg <= head.cct_invalid;

            p_reg    <= SUM_W'(mr_reg) + SUM_W'(mg_reg) - SUM_W'(mb_reg);
            cn2_reg  <= cn1_reg;
            rc2_reg  <= rc1_reg;
            inv2_reg <= inv1_reg;

            num_reg  <= {p_ext[NUM_W-6:0], 5'b00000} - p_ext;
            cn3_reg  <= cn2_reg;
            rc3_reg  <= rc2_reg;
            inv3_reg <= inv2_reg;
        end
    end

    rgbc_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s3_valid_reg),
        .lux_num   (num_reg[LNUM_W-1:0]),
        .lux_den   (lux_den),
        .cct_num   (cn3_reg),
        .cct_den   (rc3_reg),
        .in_flags  (div_flags),
        .out_valid (d_valid),
        .lux_q     (lux_q),
        .cct_q     (cct_q),
        .out_flags (d_flags)
    );

    always_comb
    begin
        ct_sum = {1'b0, cct_q} + (CH_W + 1)'(CCT_OFFSET);
        if (d_flags.lux_neg)
            lux_next = '0;
        else if (d_flags.lux_ovf)
            lux_next = '1;
        else
            lux_next = lux_q;
        if (d_flags.cct_invalid)
            ct_next = '0;
        else if (d_flags.cct_ovf || ct_sum[CH_W])
            ct_next = '1;
        else
            ct_next = ct_sum[CH_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= d_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lux_reg  <= lux_next;
            clip_reg <= d_flags.lux_neg || d_flags.lux_ovf;
            ct_reg   <= ct_next;
            inv_reg  <= d_flags.cct_invalid;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.lux         = lux_reg;
    assign result.lux_clipped = clip_reg;
    assign result.color_temp  = ct_reg;
    assign result.cct_invalid = inv_reg;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import rgbc_pkg::*;

    // ------------------------------------------------------------------
    // local types: one raw sample and one lux / color temperature reading
    // ------------------------------------------------------------------
    typedef struct packed {
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
        logic [CH_W-1:0] c;
    } sample_t;

    typedef struct packed {
        logic [CH_W-1:0] lux;
        logic            lux_clipped;
        logic [CH_W-1:0] color_temp;
        logic            cct_invalid;
    } reading_t;

    // one directed stimulus row: settings to run it under, the sample, and
    // the reading when it is obvious (known = 1), else the predictor decides
    typedef struct packed {
        logic [ATIME_W-1:0] atime;
        logic [GAIN_W-1:0]  gain;
        sample_t            smp;
        logic               known;
        reading_t           want;
    } row_t;

    // ------------------------------------------------------------------
    // constants of the lux and color temperature math
    // ------------------------------------------------------------------
    localparam longint W_RED      = 136;
    localparam longint W_GREEN    = 1000;
    localparam longint W_BLUE     = 444;
    localparam longint LUX_MUL    = 31;
    localparam longint LUX_DIV    = 240;
    localparam longint CCT_MUL    = 3810;
    localparam longint CCT_BIAS   = 1391;
    localparam longint CH_MAX     = 65535;
    localparam int     GAIN_MULT [4] = '{1, 4, 16, 60};

    // run shaping
    localparam int IDLE_PCT       = 19;     // idle chance per cycle, percent
    localparam int HOLD_CYCLES    = 80;     // long result back-pressure stretch
    localparam int SETTLE_CYCLES  = 40;     // margin beyond the pipeline latency
    localparam int WATCHDOG_LIMIT = 3000;   // cycles with no transfer at all
    localparam int PHASES         = 6;
    localparam int ITEMS_PER_PHASE = 300;

    localparam logic [CH_W-1:0] FULL      = 16'hFFFF;
    localparam reading_t        PREDICTED = '0;

    // directed table: extremes, clipping both ways, zero numerator, zero
    // corrected red, color temperature saturation, infrared wraparound,
    // and the extreme settings of integration time and gain
    row_t directed_rows [24] = '{
        '{8'd255, 2'd0, '{16'd0, 16'd0, 16'd0, 16'd0}, 1'b1, '{16'd0, 1'b0, 16'd0, 1'b1}},
        '{8'd255, 2'd0, '{16'd0, 16'd0, FULL, FULL}, 1'b1, '{16'd0, 1'b1, 16'd0, 1'b1}},
        '{8'd255, 2'd0, '{16'd0, FULL, 16'd0, FULL}, 1'b1, '{FULL, 1'b1, 16'd0, 1'b1}},
        '{8'd255, 2'd0, '{16'd1, 16'd0, FULL, FULL}, 1'b1, '{16'd0, 1'b1, FULL, 1'b0}},
        '{8'd255, 2'd0, '{16'd1, 16'd0, 16'd0, FULL}, 1'b1, '{16'd17, 1'b0, 16'd1391, 1'b0}},
        '{8'd255, 2'd0, '{16'd0, 16'd444, 16'd1000, FULL}, 1'b1,
          '{16'd0, 1'b0, 16'd0, 1'b1}},
        '{8'd255, 2'd0, '{FULL, FULL, FULL, 16'd0}, 1'b0, PREDICTED},
        '{8'd255, 2'd0, '{16'd0, 16'd100, 16'd100, 16'd0}, 1'b0, PREDICTED},
        '{8'd255, 2'd0, '{16'd3, 16'd0, 16'd0, 16'd0}, 1'b0, PREDICTED},
        '{8'd255, 2'd0, '{FULL, FULL, FULL, FULL}, 1'b0, PREDICTED},
        '{8'd255, 2'd0, '{16'd100, 16'd200, 16'd50, 16'd400}, 1'b0, PREDICTED},
        '{8'd255, 2'd0, '{16'd0, 16'd507, 16'd0, FULL}, 1'b0, PREDICTED},
        '{8'd255, 2'd0, '{16'd0, 16'd508, 16'd0, FULL}, 1'b0, PREDICTED},
        '{8'd255, 2'd0, '{16'd1, 16'd0, 16'd16, FULL}, 1'b0, PREDICTED},
        '{8'd255, 2'd0, '{16'd1, 16'd0, 16'd17, FULL}, 1'b0, PREDICTED},
        '{8'd0, 2'd3, '{16'd0, FULL, 16'd0, FULL}, 1'b0, PREDICTED},
        '{8'd0, 2'd3, '{FULL, FULL, FULL, 16'd0}, 1'b0, PREDICTED},
        '{8'd0, 2'd3, '{FULL, FULL, 16'd0, FULL}, 1'b0, PREDICTED},
        '{8'd0, 2'd3, '{16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA}, 1'b0, PREDICTED},
        '{8'd0, 2'd1, '{16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555}, 1'b0, PREDICTED},
        '{8'd128, 2'd2, '{16'd1000, 16'd30000, 16'd2000, FULL}, 1'b0, PREDICTED},
        '{8'd128, 2'd2, '{16'd0, 16'd0, 16'd0, FULL}, 1'b1, '{16'd0, 1'b0, 16'd0, 1'b1}},
        '{8'd255, 2'd3, '{16'd0, FULL, 16'd0, FULL}, 1'b0, PREDICTED},
        '{8'd255, 2'd3, '{FULL, 16'd0, 16'd0, FULL}, 1'b0, PREDICTED}
    };

    // ------------------------------------------------------------------
    // clock, reset, channels and the block
    // ------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;

    always #5 clk = ~clk;

    rgbc_cfg_if cfg_bus ();
    rgbc_in_if  sample_bus ();
    rgbc_out_if result_bus ();

    rgbc_lux_color_temperature_unit u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_bus),
        .sample (sample_bus),
        .result (result_bus)
    );

    // settings as the block should hold them, updated on each write transfer
    logic [ATIME_W-1:0] model_atime = ATIME_RESET;
    logic [GAIN_W-1:0]  model_gain  = GAIN_RESET;

    reading_t awaited_readings [$];     // readings still owed by the block, oldest first
    int       fail_count    = 0;
    bit       steady_flow   = 1'b0;     // no random idling on either side while set
    bit       hold_request  = 1'b0;     // asks the result side for a long stall

    // ------------------------------------------------------------------
    // predictor: corrected channels, lux and color temperature of a sample
    // ------------------------------------------------------------------
    function automatic reading_t predict_reading(sample_t s, logic [ATIME_W-1:0] at,
                                                 logic [GAIN_W-1:0] gn);
        longint   r, g, b, c, total, infra, rc, gcor, bc, num, den, quo, cct;
        reading_t y;
        r = longint'(s.r);
        g = longint'(s.g);
        b = longint'(s.b);
        c = longint'(s.c);
        total = r + g + b;
        // infrared estimate, kept to 16 bits; corrected channels wrap as well
        infra = (total > c) ? (((total - c) >> 1) & CH_MAX) : 0;
        rc    = (r - infra) & CH_MAX;
        gcor  = (g - infra) & CH_MAX;
        bc    = (b - infra) & CH_MAX;
        num   = (W_RED * rc + W_GREEN * gcor - W_BLUE * bc) * LUX_MUL;
        den   = LUX_DIV * (256 - longint'(at)) * longint'(GAIN_MULT[gn]);
        y = '0;
        if (num < 0)
        begin
            y.lux_clipped = 1'b1;
        end
        else
        begin
            quo = num / den;
            if (quo > CH_MAX)
            begin
                y.lux         = FULL;
                y.lux_clipped = 1'b1;
            end
            else
            begin
                y.lux = 16'(quo);
            end
        end
        if (rc == 0)
        begin
            y.cct_invalid = 1'b1;
        end
        else
        begin
            cct = CCT_MUL * bc / rc + CCT_BIAS;
            y.color_temp = (cct > CH_MAX) ? FULL : 16'(cct);
        end
        return y;
    endfunction

    // random sample drawn from one of several shapes, so that clipping,
    // in-range lux, infrared near zero and zero corrected red all show up
    function automatic sample_t random_sample();
        sample_t         s;
        logic [CH_W-1:0] mask;
        int              total;
        mask = 16'((32'd1 << $urandom_range(0, 16)) - 1);
        case ($urandom_range(0, 4))
            0:
            begin
                s = sample_t'({$urandom, $urandom});
            end
            1:
            begin
                s.r = 16'($urandom) & mask;
                s.g = 16'($urandom) & mask;
                s.b = 16'($urandom) & mask;
                s.c = 16'($urandom) & mask;
            end
            2:
            begin
                // clear close to r+g+b: infrared right at the edge of zero
                s.r = 16'($urandom_range(0, 16383));
                s.g = 16'($urandom_range(0, 16383));
                s.b = 16'($urandom_range(0, 16383));
                total = int'(s.r) + int'(s.g) + int'(s.b) + int'($urandom_range(0, 4)) - 2;
                if (total < 0)
                    total = 0;
                s.c = (total > 65535) ? FULL : 16'(total);
            end
            3:
            begin
                // moderate green keeps lux in range under most settings
                s.r = 16'($urandom_range(0, 4000));
                s.g = 16'($urandom_range(0, 700));
                s.b = 16'($urandom_range(0, 4000));
                s.c = 16'($urandom);
            end
            default:
            begin
                s   = sample_t'({$urandom, $urandom});
                s.r = 16'($urandom_range(0, 1));
            end
        endcase
        return s;
    endfunction

    // ------------------------------------------------------------------
    // configuration channel
    // ------------------------------------------------------------------
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do @(posedge clk); while (!cfg_bus.ready);
        // index beyond the two registers is dropped, gain keeps its low bits
        case (idx)
            REG_ATIME: model_atime = value;
            REG_GAIN:  model_gain  = value[GAIN_W-1:0];
            default:   ;
        endcase
    endtask

    // stop offering samples and wait until every owed reading has come back
    task automatic drain_results();
        sample_bus.valid <= 1'b0;
        while (awaited_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // settings change only with the pipeline empty; a write to an unused
    // index and junk in the upper gain bits ride along each time
    task automatic load_config(input logic [ATIME_W-1:0] at, input logic [GAIN_W-1:0] gn);
        logic [CFG_DATA_W-1:0] gain_word;
        gain_word = 8'($urandom);
        gain_word[GAIN_W-1:0] = gn;
        drain_results();
        write_register(REG_ATIME, at);
        write_register(CFG_IDX_W'($urandom_range(2, 15)), 8'($urandom));
        write_register(REG_GAIN, gain_word);
        cfg_bus.valid <= 1'b0;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // sample channel
    // ------------------------------------------------------------------
    task automatic offer_sample(input sample_t s, input reading_t want);
        sample_bus.valid     <= 1'b1;
        sample_bus.red_raw   <= s.r;
        sample_bus.green_raw <= s.g;
        sample_bus.blue_raw  <= s.b;
        sample_bus.clear_raw <= s.c;
        do @(posedge clk); while (!sample_bus.ready);
        awaited_readings.push_back(want);
    endtask

    task automatic pause_samples(input int cycles);
        sample_bus.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // main stimulus: reset, directed table, then random phases
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        sample_t            s;
        logic [ATIME_W-1:0] at;
        logic [GAIN_W-1:0]  gn;
        reading_t           want;

        rst_n                <= 1'b0;
        cfg_bus.valid        <= 1'b0;
        cfg_bus.index        <= '0;
        cfg_bus.data         <= '0;
        sample_bus.valid     <= 1'b0;
        sample_bus.red_raw   <= '0;
        sample_bus.green_raw <= '0;
        sample_bus.blue_raw  <= '0;
        sample_bus.clear_raw <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows; the first ones run on the reset settings untouched
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].atime !== model_atime || directed_rows[i].gain !== model_gain)
                load_config(directed_rows[i].atime, directed_rows[i].gain);
            want = directed_rows[i].known ? directed_rows[i].want
                 : predict_reading(directed_rows[i].smp, model_atime, model_gain);
            offer_sample(directed_rows[i].smp, want);
        end

        // random phases, each under its own settings, extremes first
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    at = 8'd0;
                    gn = 2'd0;
                end
                1:
                begin
                    at = 8'd255;
                    gn = 2'd3;
                end
                2:
                begin
                    at = 8'd0;
                    gn = 2'd3;
                end
                default:
                begin
                    at = 8'($urandom);
                    gn = 2'($urandom);
                end
            endcase
            load_config(at, gn);
            steady_flow = (phase == 4);
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                // long result stall while samples keep coming: fills the queue
                if (k == 60 && (phase == 1 || phase == 4))
                    hold_request = 1'b1;
                // sender goes quiet until the block has caught up
                if (k == 150 && phase == 3)
                    drain_results();
                // each idle cycle drawn on its own
                while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT)
                    pause_samples(1);
                s = random_sample();
                offer_sample(s, predict_reading(s, model_atime, model_gain));
            end
        end
        steady_flow = 1'b0;

        // everything owed must arrive, then no stray readings may follow
        drain_results();
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // result side: random back-pressure, long holds, and checking
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int       hold_left;
        reading_t want;
        hold_left = 0;
        result_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_bus.valid && result_bus.ready)
            begin
                if (awaited_readings.size() == 0)
                begin
                    $display("%0t: reading transfer with none owed, actual lux=%0d clip=%0b",
                             $time, result_bus.lux, result_bus.lux_clipped);
                    fail_count++;
                end
                else
                begin
                    want = awaited_readings.pop_front();
                    if (result_bus.lux !== want.lux
                        || result_bus.lux_clipped !== want.lux_clipped
                        || result_bus.color_temp !== want.color_temp
                        || result_bus.cct_invalid !== want.cct_invalid)
                    begin
                        $display("%0t: reading mismatch, expected lux=%0d clip=%0b cct=%0d inv=%0b",
                                 $time, want.lux, want.lux_clipped, want.color_temp,
                                 want.cct_invalid);
                        $display("%0t:                   actual   lux=%0d clip=%0b cct=%0d inv=%0b",
                                 $time, result_bus.lux, result_bus.lux_clipped,
                                 result_bus.color_temp, result_bus.cct_invalid);
                        fail_count++;
                    end
                end
            end
            // long hold is counted here, not by the stimulus
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_bus.ready <= 1'b0;
            end
            else
            begin
                result_bus.ready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: too long without any transfer on any channel
    // ------------------------------------------------------------------
    int stall_cycles = 0;

    always @(posedge clk)
    begin
        if ((sample_bus.valid && sample_bus.ready) || (result_bus.valid && result_bus.ready)
            || (cfg_bus.valid && cfg_bus.ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule
